### design/hcc_pkg.sv
// HChaCha20 subkey block: shared types, constants and helper functions.
// No dependencies; hcc_cell, hcc_outbuf and hchacha20_subkey refer to this package by scoped name.

package hcc_pkg;

  typedef logic [31:0] word_t;
  // Sixteen 32-bit state words, word i at [i].
  typedef logic [15:0][31:0] state_t;

  typedef struct packed {
    logic [63:0] subkey_3;
    logic [63:0] subkey_2;
    logic [63:0] subkey_1;
    logic [63:0] subkey_0;
  } subkey_t;

  typedef enum logic [1:0] {
    REG_KEY_WORD_0 = 2'd0,
    REG_KEY_WORD_1 = 2'd1,
    REG_KEY_WORD_2 = 2'd2,
    REG_KEY_WORD_3 = 2'd3
  } cfg_reg_e;

  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned KEY_REGS    = 4;

  localparam int unsigned DOUBLE_ROUNDS_DEF = 10;
  // Cells per double round: two half rounds of four quarter-round steps each.
  localparam int unsigned STEPS_PER_DR = 8;

  // "expand 32-byte k"
  localparam logic [3:0][31:0] SIGMA = {
    32'h6B206574, 32'h79622D32, 32'h3320646E, 32'h61707865
  };

  function automatic word_t rotl32(input word_t v, input logic [4:0] n);
    return (v << n) | (v >> (6'd32 - {1'b0, n}));
  endfunction

  // Rotation used by quarter-round step 0..3.
  function automatic logic [4:0] rot_amount(input logic [1:0] sub);
    logic [4:0] r;
    unique case (sub)
      2'd0: r = 5'd16;
      2'd1: r = 5'd12;
      2'd2: r = 5'd8;
      default: r = 5'd7;
    endcase
    return r;
  endfunction

  // State word of role a/b/c/d (0..3) for a lane in a column or diagonal half round.
  function automatic logic [3:0] qr_idx(input logic diag, input logic [1:0] lane,
                                        input logic [1:0] role);
    logic [1:0] col;
    col = lane + (diag ? role : 2'd0);
    return {role, col};
  endfunction

endpackage

### design/hcc_channels.sv
// HChaCha20 subkey block: valid/ready channel interfaces for nonce and subkey.
// No dependencies.

interface hcc_nonce_if;
  logic        valid;
  logic        ready;
  logic [63:0] nonce_low;
  logic [63:0] nonce_high;

  modport source (output valid, output nonce_low, output nonce_high, input ready);
  modport sink   (input valid, input nonce_low, input nonce_high, output ready);
endinterface

interface hcc_subkey_if;
  logic        valid;
  logic        ready;
  logic [63:0] subkey_0;
  logic [63:0] subkey_1;
  logic [63:0] subkey_2;
  logic [63:0] subkey_3;

  modport source (output valid, output subkey_0, output subkey_1, output subkey_2,
                  output subkey_3, input ready);
  modport sink   (input valid, input subkey_0, input subkey_1, input subkey_2,
                  input subkey_3, output ready);
endinterface

### design/hcc_cell.sv
// HChaCha20 subkey block: one pipeline cell, one quarter-round step on four lanes.
// Depends on hcc_pkg.

module hcc_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  hcc_pkg::state_t state_i,
  output logic            valid_o,
  output hcc_pkg::state_t state_o
);

  localparam logic [1:0] SUB  = 2'(STEP % 4);
  localparam logic       DIAG = 1'((STEP / 4) % 2);
  localparam logic [4:0] ROT  = hcc_pkg::rot_amount(SUB);
  // Even steps: a += b, d ^= a. Odd steps: c += d, b ^= c.
  localparam logic [1:0] ROLE_X = SUB[0] ? 2'd2 : 2'd0;
  localparam logic [1:0] ROLE_Y = SUB[0] ? 2'd3 : 2'd1;
  localparam logic [1:0] ROLE_Z = SUB[0] ? 2'd1 : 2'd3;

  logic            valid_q;
  hcc_pkg::state_t state_q, state_d;

  always_comb begin
    logic [3:0]     xi, yi, zi;
    hcc_pkg::word_t sum;
    state_d = state_i;
    for (int l = 0; l < 4; l++) begin
      xi = hcc_pkg::qr_idx(DIAG, 2'(l), ROLE_X);
      yi = hcc_pkg::qr_idx(DIAG, 2'(l), ROLE_Y);
      zi = hcc_pkg::qr_idx(DIAG, 2'(l), ROLE_Z);
      sum = state_i[xi] + state_i[yi];
      state_d[xi] = sum;
      state_d[zi] = hcc_pkg::rotl32(state_i[zi] ^ sum, ROT);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      state_q <= state_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;

endmodule

### design/hcc_outbuf.sv
// HChaCha20 subkey block: two-entry output skid buffer (head register plus spare).
// Depends on hcc_pkg.

module hcc_outbuf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  hcc_pkg::subkey_t data_i,
  output logic             ready_o,
  output logic             valid_o,
  output hcc_pkg::subkey_t data_o,
  input  logic             pop_i
);

  logic             head_v_q, head_v_d;
  logic             spare_v_q, spare_v_d;
  hcc_pkg::subkey_t head_q, head_d;
  hcc_pkg::subkey_t spare_q, spare_d;
  logic             head_free;

  assign head_free = !head_v_q || pop_i;

  always_comb begin
    head_v_d  = head_v_q;
    spare_v_d = spare_v_q;
    head_d    = head_q;
    spare_d   = spare_q;
    if (head_free) begin
      if (spare_v_q) begin
        head_d    = spare_q;
        head_v_d  = 1'b1;
        spare_d   = data_i;
        spare_v_d = push_i;
      end else begin
        head_d    = data_i;
        head_v_d  = push_i;
      end
    end else if (push_i) begin
      spare_d   = data_i;
      spare_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_v_q  <= 1'b0;
      spare_v_q <= 1'b0;
    end else begin
      head_v_q  <= head_v_d;
      spare_v_q <= spare_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q  <= head_d;
    spare_q <= spare_d;
  end

  // Registered: upstream only advances while the spare slot is empty.
  assign ready_o = !spare_v_q;
  assign valid_o = head_v_q;
  assign data_o  = head_q;

`ifndef SYNTHESIS
  a_spare_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    spare_v_q |-> head_v_q)
    else $error("spare entry held while head empty");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ready_o |-> !push_i)
    else $error("transfer pushed into full output buffer");

  a_full_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (spare_v_q && pop_i) |=> (head_v_q && !spare_v_q))
    else $error("spare entry lost or kept after head transfer");
`endif

endmodule

### design/hchacha20_subkey.sv
// HChaCha20 subkey derivation. Four 64-bit key registers (index 0..3, little-endian key
// bytes 0..31) are loaded with the sigma constants and each transferred nonce into the
// 16-word ChaCha state, which then runs through a chain of 8*DOUBLE_ROUNDS cells, one
// quarter-round step per cell on all four columns or diagonals at once. The subkey is
// state words 0..3 and 12..15, no feed-forward. One nonce is taken every cycle while the
// spare output entry is empty; each result passes through the cell chain and then the
// output buffer, which has two entries and decouples the ready signals: a stalled
// subkey port freezes the whole chain only once the spare entry fills, and nonce
// ready is a flop. Key writes must land while no nonce is in flight.
// Depends on hcc_pkg, hcc_channels, hcc_cell and hcc_outbuf.

module hchacha20_subkey #(
  parameter int unsigned DOUBLE_ROUNDS = hcc_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  hcc_nonce_if.sink                      nonce_i,
  hcc_subkey_if.source                   subkey_o,
  input  logic                           cfg_we_i,
  input  logic [hcc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [hcc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned NCELLS = DOUBLE_ROUNDS * hcc_pkg::STEPS_PER_DR;

  // Key registers
  logic [hcc_pkg::KEY_REGS-1:0][hcc_pkg::CFG_DATA_W-1:0] key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_we_i) begin
      unique case (hcc_pkg::cfg_reg_e'(cfg_idx_i))
        hcc_pkg::REG_KEY_WORD_0: key_q[0] <= cfg_wdata_i;
        hcc_pkg::REG_KEY_WORD_1: key_q[1] <= cfg_wdata_i;
        hcc_pkg::REG_KEY_WORD_2: key_q[2] <= cfg_wdata_i;
        hcc_pkg::REG_KEY_WORD_3: key_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Chain control: every cell moves together while the output buffer has room.
  logic             chain_en;
  logic             nonce_xfer;
  logic [NCELLS:0]  cell_valid;
  hcc_pkg::state_t  init_state;
  hcc_pkg::state_t  cell_state [NCELLS+1];
  hcc_pkg::subkey_t result;

  assign nonce_i.ready = chain_en;
  assign nonce_xfer    = nonce_i.valid && chain_en;

  // Initial state: sigma, key words 4..11, nonce words 12..15.
  always_comb begin
    init_state[3:0] = hcc_pkg::SIGMA;
    for (int i = 0; i < 4; i++) begin
      init_state[4 + 2*i] = key_q[i][31:0];
      init_state[5 + 2*i] = key_q[i][63:32];
    end
    init_state[12] = nonce_i.nonce_low[31:0];
    init_state[13] = nonce_i.nonce_low[63:32];
    init_state[14] = nonce_i.nonce_high[31:0];
    init_state[15] = nonce_i.nonce_high[63:32];
  end
  assign cell_state[0] = init_state;
  assign cell_valid[0] = nonce_xfer;

  for (genvar k = 0; k < NCELLS; k++) begin : g_cell
    hcc_cell #(
      .STEP (k % hcc_pkg::STEPS_PER_DR)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (chain_en),
      .valid_i (cell_valid[k]),
      .state_i (cell_state[k]),
      .valid_o (cell_valid[k+1]),
      .state_o (cell_state[k+1])
    );
  end

  // Subkey: words 0..3 and 12..15, low word in the low half of each field.
  assign result.subkey_0 = {cell_state[NCELLS][1],  cell_state[NCELLS][0]};
  assign result.subkey_1 = {cell_state[NCELLS][3],  cell_state[NCELLS][2]};
  assign result.subkey_2 = {cell_state[NCELLS][13], cell_state[NCELLS][12]};
  assign result.subkey_3 = {cell_state[NCELLS][15], cell_state[NCELLS][14]};

  hcc_pkg::subkey_t out_data;

  hcc_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (chain_en && cell_valid[NCELLS]),
    .data_i  (result),
    .ready_o (chain_en),
    .valid_o (subkey_o.valid),
    .data_o  (out_data),
    .pop_i   (subkey_o.ready)
  );

  assign subkey_o.subkey_0 = out_data.subkey_0;
  assign subkey_o.subkey_1 = out_data.subkey_1;
  assign subkey_o.subkey_2 = out_data.subkey_2;
  assign subkey_o.subkey_3 = out_data.subkey_3;

`ifndef SYNTHESIS
  a_stall_means_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !nonce_i.ready |-> subkey_o.valid)
    else $error("nonce port stalled with no subkey waiting");

  a_frozen_chain_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !chain_en |=> $stable(cell_valid[NCELLS:1]))
    else $error("cell chain moved while frozen");

  a_first_cell_tracks_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_en |=> (cell_valid[1] == $past(nonce_xfer)))
    else $error("first cell does not reflect nonce transfer");
`endif

endmodule

### tb/sv/hchacha20_subkey_test.sv
// Self-checking testbench for hchacha20_subkey: nonce and subkey valid/ready channels,
// 64-bit key write port. Depends on hcc_pkg, hcc_channels and the hchacha20_subkey RTL.
`timescale 1ns / 100ps

module hchacha20_subkey_test;

  localparam int unsigned DR         = hcc_pkg::DOUBLE_ROUNDS_DEF;
  // Nonce-to-subkey latency of the round chain plus output register.
  localparam int unsigned LATENCY    = 8 * DR + 1;
  localparam int unsigned HOLD_LEN   = 400;
  localparam int unsigned RAND_SETS  = 6;
  localparam int unsigned SET_ITEMS  = 300;
  localparam int unsigned MAX_REPORT = 10;
  // Watchdog bound on the whole run, well above the slowest legal run.
  localparam longint unsigned CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic [63:0] high;
    logic [63:0] low;
  } nonce_t;

  logic clk_i;
  logic rst_ni;
  logic                           cfg_we_i;
  logic [hcc_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [hcc_pkg::CFG_DATA_W-1:0] cfg_wdata_i;

  hcc_nonce_if  nonce_if ();
  hcc_subkey_if subkey_if ();

  hchacha20_subkey #(
    .DOUBLE_ROUNDS (DR)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .nonce_i     (nonce_if),
    .subkey_o    (subkey_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // 12 ns period
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Shared state
  // ---------------------------------------------------------------------------
  logic [63:0]      key_model [hcc_pkg::KEY_REGS];   // our copy of the key registers
  nonce_t           nonce_backlog [$];      // nonces waiting to be offered
  hcc_pkg::subkey_t subkey_due [$];         // subkeys predicted, not yet seen
  bit           idle_on;                // random gaps/stalls enabled
  bit           hold_start;             // request a long receiver hold-off
  int unsigned  hold_left;
  int unsigned  send_gap;
  int unsigned  recv_stall;
  int unsigned  mismatches;
  int unsigned  nonces_sent;
  int unsigned  subkeys_seen;
  int unsigned  key_sets;
  longint unsigned cycles;

  // ---------------------------------------------------------------------------
  // Predictor: HChaCha20 core, no feed-forward
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic hcc_pkg::state_t qround(input hcc_pkg::state_t s, input int a,
                                             input int b, input int c, input int d);
    s[a] = s[a] + s[b]; s[d] = rol32(s[d] ^ s[a], 16);
    s[c] = s[c] + s[d]; s[b] = rol32(s[b] ^ s[c], 12);
    s[a] = s[a] + s[b]; s[d] = rol32(s[d] ^ s[a], 8);
    s[c] = s[c] + s[d]; s[b] = rol32(s[b] ^ s[c], 7);
    return s;
  endfunction

  function automatic hcc_pkg::subkey_t derive_subkey(input nonce_t n);
    hcc_pkg::state_t  s;
    hcc_pkg::subkey_t k;
    for (int i = 0; i < 4; i++) begin
      s[i]         = hcc_pkg::SIGMA[i];
      s[4 + 2 * i] = key_model[i][31:0];
      s[5 + 2 * i] = key_model[i][63:32];
    end
    s[12] = n.low[31:0];
    s[13] = n.low[63:32];
    s[14] = n.high[31:0];
    s[15] = n.high[63:32];
    for (int r = 0; r < DR; r++) begin
      // columns
      s = qround(s, 0, 4, 8, 12);
      s = qround(s, 1, 5, 9, 13);
      s = qround(s, 2, 6, 10, 14);
      s = qround(s, 3, 7, 11, 15);
      // diagonals
      s = qround(s, 0, 5, 10, 15);
      s = qround(s, 1, 6, 11, 12);
      s = qround(s, 2, 7, 8, 13);
      s = qround(s, 3, 4, 9, 14);
    end
    k.subkey_0 = {s[1], s[0]};
    k.subkey_1 = {s[3], s[2]};
    k.subkey_2 = {s[13], s[12]};
    k.subkey_3 = {s[15], s[14]};
    return k;
  endfunction

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------
  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // 64-bit value biased towards extremes and single-bit patterns.
  function automatic logic [63:0] pick_word();
    logic [63:0] one_hot;
    one_hot = 64'd1 << $urandom_range(0, 63);
    unique case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return one_hot;
      3:       return ~one_hot;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Nonce driver
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    bit accepted;
    if (!rst_ni) begin
      nonce_if.valid <= 1'b0;
      send_gap = 0;
    end else begin
      accepted = nonce_if.valid && nonce_if.ready;
      if (accepted) begin
        // Key is stable while nonces are in flight, so predict on transfer.
        subkey_due.push_back(derive_subkey(nonce_backlog[0]));
        void'(nonce_backlog.pop_front());
        nonces_sent++;
        send_gap = pick_gap();
      end
      if (nonce_if.valid && !accepted) begin
        // hold the offer until it is taken
      end else if (send_gap == 0 && nonce_backlog.size() != 0) begin
        nonce_if.valid      <= 1'b1;
        nonce_if.nonce_low  <= nonce_backlog[0].low;
        nonce_if.nonce_high <= nonce_backlog[0].high;
      end else begin
        nonce_if.valid <= 1'b0;
        if (send_gap != 0) send_gap--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Long receiver hold-off, counted here
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_start) begin
      hold_left <= HOLD_LEN;
      hold_start = 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Subkey monitor and checker
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    hcc_pkg::subkey_t got;
    hcc_pkg::subkey_t want;
    if (!rst_ni) begin
      subkey_if.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (subkey_if.valid && subkey_if.ready) begin
        got = {subkey_if.subkey_3, subkey_if.subkey_2, subkey_if.subkey_1,
               subkey_if.subkey_0};
        subkeys_seen++;
        if (subkey_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORT)
            $display("[%0t] unexpected subkey transfer %h", $realtime, got);
        end else begin
          want = subkey_due.pop_front();
          for (int f = 0; f < 4; f++) begin
            if (got[f * 64 +: 64] !== want[f * 64 +: 64]) begin
              mismatches++;
              if (mismatches <= MAX_REPORT)
                $display("[%0t] subkey_%0d mismatch: expected %h, got %h",
                         $realtime, f, want[f * 64 +: 64], got[f * 64 +: 64]);
            end
          end
        end
      end
      if (hold_left != 0) begin
        subkey_if.ready <= 1'b0;
      end else if (recv_stall != 0) begin
        subkey_if.ready <= 1'b0;
        recv_stall--;
      end else begin
        subkey_if.ready <= 1'b1;
        recv_stall = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d subkeys outstanding", cycles,
               subkey_due.size());
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_nonce(input logic [63:0] lo, input logic [63:0] hi);
    nonce_t n;
    n.low  = lo;
    n.high = hi;
    nonce_backlog.push_back(n);
  endtask

  // Write all four key registers; only called while nothing is in flight.
  task automatic load_key(input logic [63:0] k0, input logic [63:0] k1,
                          input logic [63:0] k2, input logic [63:0] k3);
    logic [63:0]       kv [hcc_pkg::KEY_REGS];
    hcc_pkg::cfg_reg_e idx;
    kv = '{k0, k1, k2, k3};
    for (int i = 0; i < hcc_pkg::KEY_REGS; i++) begin
      idx = hcc_pkg::cfg_reg_e'(i);
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx;
      cfg_wdata_i <= kv[i];
      key_model[idx] = kv[i];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    key_sets++;
  endtask

  // Block until every nonce is taken and every subkey has come back.
  task automatic wait_idle();
    while (nonce_backlog.size() != 0 || nonce_if.valid || subkey_due.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    // Known values from time zero
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = hcc_pkg::REG_KEY_WORD_0;
    cfg_wdata_i         = '0;
    nonce_if.valid      = 1'b0;
    nonce_if.nonce_low  = '0;
    nonce_if.nonce_high = '0;
    subkey_if.ready     = 1'b0;
    idle_on             = 1'b1;
    hold_start          = 1'b0;
    hold_left           = 0;
    mismatches          = 0;
    nonces_sent         = 0;
    subkeys_seen        = 0;
    key_sets            = 0;
    cycles              = 0;
    for (int i = 0; i < hcc_pkg::KEY_REGS; i++) key_model[i] = '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed, key left at its reset value of zero
    @(negedge clk_i);
    queue_nonce('0, '0);
    queue_nonce('1, '1);
    queue_nonce(64'd1, '0);
    queue_nonce('0, 64'h8000_0000_0000_0000);
    queue_nonce(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    queue_nonce(64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF);
    queue_nonce(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
    wait_idle();

    // Directed, standard test vector: key bytes 00..1f
    load_key(64'h0706_0504_0302_0100, 64'h0F0E_0D0C_0B0A_0908,
             64'h1716_1514_1312_1110, 64'h1F1E_1D1C_1B1A_1918);
    @(negedge clk_i);
    queue_nonce(64'h4A00_0000_0900_0000, 64'h2759_4131_0000_0000);
    queue_nonce('0, '0);
    queue_nonce('1, '1);
    wait_idle();

    // Directed, all-ones key
    load_key('1, '1, '1, '1);
    @(negedge clk_i);
    queue_nonce('0, '0);
    queue_nonce('1, '1);
    queue_nonce('1, '0);
    queue_nonce('0, '1);
    queue_nonce(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    wait_idle();

    // Random sets, each under a newly loaded key (fixed patterns in sets 1 and 2)
    for (int set = 0; set < RAND_SETS; set++) begin
      unique case (set)
        1:       load_key('1, '0, '1, '0);
        2:       load_key('0, '0, '0, '0);
        default: load_key(pick_word(), pick_word(), pick_word(), pick_word());
      endcase
      @(negedge clk_i);
      // set 4 streams with no idling; set 5 adds the long hold-off
      idle_on = !(set == 4 || set == 5);
      for (int i = 0; i < SET_ITEMS; i++)
        queue_nonce(pick_word(), pick_word());
      if (set == 5) begin
        // Let nonces enter the pipeline, then block the output while nonces keep coming.
        repeat (20) @(posedge clk_i);
        @(negedge clk_i);
        hold_start = 1'b1;
      end
      wait_idle();
      @(negedge clk_i);
      idle_on = 1'b1;
    end

    // Catch any stray subkey after the last expected one
    repeat (LATENCY + 20) @(posedge clk_i);

    $display("Sent %0d nonces under %0d key loads, checked %0d subkeys.",
             nonces_sent, key_sets, subkeys_seen);
    $display("Covered random gaps and stalls, back-to-back streaming and a %0d-cycle hold-off.",
             HOLD_LEN);
    if (mismatches == 0 && subkey_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d subkeys missing", mismatches, subkey_due.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
design/hcc_pkg.sv
design/hcc_channels.sv
design/hcc_cell.sv
design/hcc_outbuf.sv
design/hchacha20_subkey.sv
tb/sv/hchacha20_subkey_test.sv
